FILE: hdl/remote_obstacle_follow_drive_fsm_unit_macros.svh
// Assertion macros for the drive unit checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef REMOTE_OBSTACLE_FOLLOW_DRIVE_FSM_UNIT_MACROS_SVH
`define REMOTE_OBSTACLE_FOLLOW_DRIVE_FSM_UNIT_MACROS_SVH

// same-cycle implication
`define ROFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rofd check failed");

// next-cycle implication
`define ROFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rofd check failed");

`endif

FILE: hdl/rofd_pkg.sv
// Shared types and constants for the remote drive unit.
// Used by rofd_step, the top level and the checker; depends on nothing.
package rofd_pkg;

	localparam int DIST_W       = 10;
	localparam int DIV100_SHIFT = 23;
	localparam logic [16:0] DIV100_MUL = 17'd83887;

	localparam logic [7:0] KEY_SPD_P100 = 8'h45;
	localparam logic [7:0] KEY_SPD_P75  = 8'h46;
	localparam logic [7:0] KEY_SPD_P50  = 8'h47;
	localparam logic [7:0] KEY_SPD_P25  = 8'h44;
	localparam logic [7:0] KEY_SPD_N25  = 8'h43;
	localparam logic [7:0] KEY_SPD_N50  = 8'h07;
	localparam logic [7:0] KEY_SPD_N75  = 8'h15;
	localparam logic [7:0] KEY_SPD_N100 = 8'h09;
	localparam logic [7:0] KEY_HALT     = 8'h40;
	localparam logic [7:0] KEY_STOP     = 8'h1C;
	localparam logic [7:0] KEY_SPD_INC  = 8'h16;
	localparam logic [7:0] KEY_SPD_DEC  = 8'h0D;
	localparam logic [7:0] KEY_FOLLOW   = 8'h19;
	localparam logic [7:0] KEY_AVOID    = 8'h18;
	localparam logic [7:0] KEY_BACK     = 8'h52;
	localparam logic [7:0] KEY_LEFT     = 8'h08;
	localparam logic [7:0] KEY_RIGHT    = 8'h5A;

	localparam logic [7:0] SPD_ZERO  = 8'h00;
	localparam logic [7:0] SPD_P100  = 8'd100;
	localparam logic [7:0] SPD_P75   = 8'd75;
	localparam logic [7:0] SPD_P50   = 8'd50;
	localparam logic [7:0] SPD_P25   = 8'd25;
	localparam logic [7:0] SPD_N25   = 8'hE7;
	localparam logic [7:0] SPD_N50   = 8'hCE;
	localparam logic [7:0] SPD_N75   = 8'hB5;
	localparam logic [7:0] SPD_N100  = 8'h9C;
	localparam logic [7:0] SPD_WRAP_P = 8'h65;
	localparam logic [7:0] SPD_WRAP_N = 8'h9B;
	localparam logic signed [7:0] SPD_FAR_LIMIT = 8'sd80;

	localparam logic [2:0] ACT_STOP  = 3'd0;
	localparam logic [2:0] ACT_FWD   = 3'd1;
	localparam logic [2:0] ACT_BACK  = 3'd2;
	localparam logic [2:0] ACT_LEFT  = 3'd3;
	localparam logic [2:0] ACT_RIGHT = 3'd4;

	localparam logic [1:0] MODE_MANUAL = 2'd0;
	localparam logic [1:0] MODE_AVOID  = 2'd1;
	localparam logic [1:0] MODE_FOLLOW = 2'd2;

	localparam logic [2:0] FS_NONE   = 3'd0;
	localparam logic [2:0] FS_NEAR   = 3'd1;
	localparam logic [2:0] FS_FAR    = 3'd2;
	localparam logic [2:0] FS_LOST_L = 3'd3;
	localparam logic [2:0] FS_LOST_F = 3'd4;
	localparam logic [2:0] FS_LOST_R = 3'd5;

	localparam logic [1:0] DIR_UNKNOWN = 2'd0;
	localparam logic [1:0] DIR_LEFT    = 2'd1;
	localparam logic [1:0] DIR_FRONT   = 2'd2;
	localparam logic [1:0] DIR_RIGHT   = 2'd3;

	localparam logic [1:0] CFG_AVOID_NEAR = 2'd0;
	localparam logic [1:0] CFG_AVOID_FAR  = 2'd1;
	localparam logic [1:0] CFG_FOLLOW_MIN = 2'd2;
	localparam logic [1:0] CFG_FOLLOW_MAX = 2'd3;

	localparam logic [7:0] RST_AVOID_NEAR = 8'd15;
	localparam logic [7:0] RST_AVOID_FAR  = 8'd50;
	localparam logic [7:0] RST_FOLLOW_MIN = 8'd15;
	localparam logic [7:0] RST_FOLLOW_MAX = 8'd50;

	typedef struct packed {
		logic [7:0] avoid_near;
		logic [7:0] avoid_far;
		logic [7:0] follow_min;
		logic [7:0] follow_max;
	} rofd_cfg_t;

	typedef struct packed {
		logic [7:0] speed;
		logic       avoid;
		logic       follow;
		logic [2:0] fstate;
		logic [1:0] tdir;
		logic       far_sel;
		logic [2:0] action;
		logic [7:0] aspeed;
	} rofd_state_t;

	localparam rofd_state_t STATE_RST = '{
		speed: SPD_ZERO, avoid: 1'b0, follow: 1'b0, fstate: FS_NONE,
		tdir: DIR_UNKNOWN, far_sel: 1'b0, action: ACT_STOP, aspeed: SPD_ZERO
	};

	typedef struct packed {
		logic       fresh;
		logic       rep;
		logic [7:0] key;
	} rofd_ir_t;

endpackage

FILE: hdl/rofd_step.sv
// Next-state logic for one control tick: key handling, avoid steering, follow machine.
// Depends on rofd_pkg.
module rofd_step import rofd_pkg::*; (
	input  rofd_state_t       cur,
	input  rofd_cfg_t         cfg,
	input  rofd_ir_t          ir,
	input  logic [DIST_W-1:0] ldist,
	input  logic [DIST_W-1:0] rdist,
	output rofd_state_t       nxt
);

	logic [DIST_W-1:0] thr;
	logic [DIST_W-1:0] mn;
	logic [DIST_W-1:0] mx;
	logic [2:0]        fs_key;
	logic              both_far;
	logic              fvalid;

	always_comb begin
		nxt = cur;
		if (ir.fresh || ir.rep) begin
			case (ir.key)
				KEY_SPD_P100: nxt.speed = SPD_P100;
				KEY_SPD_P75:  nxt.speed = SPD_P75;
				KEY_SPD_P50:  nxt.speed = SPD_P50;
				KEY_SPD_P25:  nxt.speed = SPD_P25;
				KEY_SPD_N25:  nxt.speed = SPD_N25;
				KEY_SPD_N50:  nxt.speed = SPD_N50;
				KEY_SPD_N75:  nxt.speed = SPD_N75;
				KEY_SPD_N100: nxt.speed = SPD_N100;
				KEY_HALT: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b0;
					nxt.speed  = SPD_ZERO;
					nxt.action = ACT_STOP;
					nxt.aspeed = SPD_ZERO;
				end
				KEY_STOP: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b0;
					nxt.action = ACT_STOP;
					nxt.aspeed = SPD_ZERO;
				end
				KEY_SPD_INC: nxt.speed = cur.speed + 8'd1;
				KEY_SPD_DEC: nxt.speed = cur.speed - 8'd1;
				KEY_FOLLOW: begin
					if (ir.fresh) begin
						nxt.follow = !cur.follow;
						nxt.avoid  = 1'b0;
						nxt.action = ACT_STOP;
						nxt.aspeed = SPD_ZERO;
						nxt.fstate = FS_NONE;
						nxt.tdir   = DIR_UNKNOWN;
					end
				end
				KEY_AVOID: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b1;
					nxt.action = ACT_FWD;
					nxt.aspeed = cur.speed;
				end
				KEY_BACK: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b0;
					nxt.action = ACT_BACK;
					nxt.aspeed = cur.speed;
				end
				KEY_LEFT: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b0;
					nxt.action = ACT_LEFT;
					nxt.aspeed = cur.speed;
				end
				KEY_RIGHT: begin
					nxt.follow = 1'b0;
					nxt.avoid  = 1'b0;
					nxt.action = ACT_RIGHT;
					nxt.aspeed = cur.speed;
				end
				default: ;
			endcase
			if (nxt.speed == SPD_WRAP_P || nxt.speed == SPD_WRAP_N) begin
				nxt.speed = SPD_ZERO;
			end
			nxt.far_sel = $signed(nxt.speed) > SPD_FAR_LIMIT;
		end

		thr      = {2'b00, (nxt.far_sel ? cfg.avoid_far : cfg.avoid_near)};
		mn       = {2'b00, cfg.follow_min};
		mx       = {2'b00, cfg.follow_max};
		both_far = (ldist > mx) && (rdist > mx);
		fs_key   = nxt.fstate;
		fvalid   = 1'b1;

		if (nxt.avoid) begin
			if (ldist < thr && rdist > thr) begin
				nxt.action = ACT_RIGHT;
				nxt.aspeed = nxt.speed;
			end else if (ldist > thr && rdist < thr) begin
				nxt.action = ACT_LEFT;
				nxt.aspeed = nxt.speed;
			end else if (ldist > thr && rdist > thr) begin
				nxt.action = ACT_FWD;
				nxt.aspeed = nxt.speed;
			end else if (ldist < thr && rdist < thr) begin
				nxt.action = ACT_RIGHT;
				nxt.aspeed = nxt.speed;
			end
		end else if (nxt.follow) begin
			case (fs_key)
				FS_NONE, FS_NEAR: begin
					nxt.action = ACT_STOP;
					nxt.aspeed = SPD_ZERO;
				end
				FS_FAR, FS_LOST_F: begin
					nxt.action = ACT_FWD;
					nxt.aspeed = nxt.speed;
				end
				FS_LOST_L: begin
					nxt.action = ACT_LEFT;
					nxt.aspeed = nxt.speed;
				end
				FS_LOST_R: begin
					nxt.action = ACT_RIGHT;
					nxt.aspeed = nxt.speed;
				end
				default: fvalid = 1'b0;
			endcase
			if (fvalid) begin
				if (ldist < mn && rdist > mn) begin
					nxt.fstate = FS_NEAR;
					nxt.tdir   = DIR_LEFT;
				end else if (ldist < mn && rdist < mn) begin
					nxt.fstate = FS_NEAR;
					nxt.tdir   = DIR_FRONT;
				end else if (ldist > mn && rdist < mn) begin
					nxt.fstate = FS_NEAR;
					nxt.tdir   = DIR_RIGHT;
				end else if (ldist > mn && ldist < mx && rdist > mx) begin
					nxt.fstate = FS_FAR;
					nxt.tdir   = DIR_LEFT;
				end else if (ldist > mn && ldist < mx && rdist > mn && rdist < mx) begin
					nxt.fstate = FS_FAR;
					nxt.tdir   = DIR_FRONT;
				end else if (ldist > mx && rdist > mn && rdist < mx) begin
					nxt.fstate = FS_FAR;
					nxt.tdir   = DIR_RIGHT;
				end else if (fs_key == FS_NONE) begin
					if (both_far) begin
						nxt.tdir = DIR_UNKNOWN;
					end
				end else if (fs_key == FS_NEAR || fs_key == FS_FAR) begin
					if (both_far && nxt.tdir != DIR_UNKNOWN) begin
						nxt.fstate = {1'b0, nxt.tdir} + 3'd2;
					end
				end
			end
		end
	end

endmodule

FILE: hdl/remote_obstacle_follow_drive_fsm_unit.sv
// Top level of the remote drive unit: input register, divide-by-100 stage, state update.
// Depends on rofd_pkg and rofd_step.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------------
//  in      | in_valid / in_ready   | ir_new_frame ir_repeat_frame ir_key_code
//          |                       | left_distance_raw right_distance_raw
//  out     | out_valid / out_ready | drive_action drive_speed speed_setting drive_mode
//          |                       | follow_state_out target_direction_out
//  cfg     | cfg_valid / cfg_ready | cfg_index cfg_data (cfg_ready is always high)
//
// One item per cycle while out_ready is high; each input passes through s1, s2 and the result registers.
// Stage s1 holds the raw item, s2 holds both distances in cm (one 16x17 multiply each),
// and the state update runs between s2 and the result registers.
// Each stage advances when the stage after it is empty or moving, so bubbles absorb stalls.
// Reset clears the pipeline, the drive state, and loads the default thresholds.
module remote_obstacle_follow_drive_fsm_unit import rofd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        ir_new_frame,
	input  logic        ir_repeat_frame,
	input  logic [7:0]  ir_key_code,
	input  logic [15:0] left_distance_raw,
	input  logic [15:0] right_distance_raw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  drive_action,
	output logic signed [7:0] drive_speed,
	output logic signed [7:0] speed_setting,
	output logic [1:0]  drive_mode,
	output logic [2:0]  follow_state_out,
	output logic [1:0]  target_direction_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic              v_s1;
	rofd_ir_t          ir_s1;
	logic [15:0]       lraw_s1;
	logic [15:0]       rraw_s1;
	logic              v_s2;
	rofd_ir_t          ir_s2;
	logic [DIST_W-1:0] ldist_s2;
	logic [DIST_W-1:0] rdist_s2;
	logic              out_valid_q;
	rofd_state_t       st_q;
	rofd_state_t       st_nxt;
	rofd_cfg_t         cfg_q;
	logic [32:0]       lprod;
	logic [32:0]       rprod;
	logic              load_out;
	logic              en_s2;
	logic              en_s1;

	assign load_out = v_s2 && (!out_valid_q || out_ready);
	assign en_s2    = !v_s2 || load_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign cfg_ready = 1'b1;

	assign lprod = {17'b0, lraw_s1} * {16'b0, DIV100_MUL};
	assign rprod = {17'b0, rraw_s1} * {16'b0, DIV100_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ir_s1   <= '{fresh: ir_new_frame, rep: ir_repeat_frame, key: ir_key_code};
			lraw_s1 <= left_distance_raw;
			rraw_s1 <= right_distance_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			ir_s2    <= ir_s1;
			ldist_s2 <= lprod[DIV100_SHIFT +: DIST_W];
			rdist_s2 <= rprod[DIV100_SHIFT +: DIST_W];
		end
	end

	rofd_step u_step (
		.cur   (st_q),
		.cfg   (cfg_q),
		.ir    (ir_s2),
		.ldist (ldist_s2),
		.rdist (rdist_s2),
		.nxt   (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			st_q        <= STATE_RST;
		end else begin
			if (load_out) begin
				st_q <= st_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{avoid_near: RST_AVOID_NEAR, avoid_far: RST_AVOID_FAR,
				follow_min: RST_FOLLOW_MIN, follow_max: RST_FOLLOW_MAX};
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AVOID_NEAR: cfg_q.avoid_near <= cfg_data;
				CFG_AVOID_FAR:  cfg_q.avoid_far  <= cfg_data;
				CFG_FOLLOW_MIN: cfg_q.follow_min <= cfg_data;
				CFG_FOLLOW_MAX: cfg_q.follow_max <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid            = out_valid_q;
	assign drive_action         = st_q.action;
	assign drive_speed          = st_q.aspeed;
	assign speed_setting        = st_q.speed;
	assign drive_mode           = st_q.avoid ? MODE_AVOID :
		(st_q.follow ? MODE_FOLLOW : MODE_MANUAL);
	assign follow_state_out     = st_q.fstate;
	assign target_direction_out = st_q.tdir;

endmodule

FILE: hdl/rofd_checker.sv
// Port-level checks for the remote drive unit, attached by bind.
// Depends on rofd_pkg and the assertion macro header.
`include "remote_obstacle_follow_drive_fsm_unit_macros.svh"

module rofd_checker import rofd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  drive_action,
	input logic [7:0]  drive_speed,
	input logic [7:0]  speed_setting,
	input logic [1:0]  drive_mode,
	input logic [2:0]  follow_state_out,
	input logic [1:0]  target_direction_out
);

	`ROFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_action) && $stable(drive_speed) && $stable(speed_setting))
	`ROFD_ASSERT_NOW(a_stop_zero, out_valid && drive_action == ACT_STOP, drive_speed == SPD_ZERO)
	`ROFD_ASSERT_NOW(a_speed_wrap, out_valid, speed_setting != SPD_WRAP_P && speed_setting != SPD_WRAP_N)
	`ROFD_ASSERT_NOW(a_follow_range, out_valid, follow_state_out <= FS_LOST_R && drive_action <= ACT_RIGHT)
	`ROFD_ASSERT_NOW(a_full_stall, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind remote_obstacle_follow_drive_fsm_unit rofd_checker u_rofd_checker (.*);
